FILE: rtl/core/tnph_pkg.sv
// ----------------------------------------------------------------------------
// tnph_pkg
// Shared types and constants for the top-N peak heap: payload structs,
// opcodes and configuration register indexes.
// ----------------------------------------------------------------------------
package tnph_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_FIRST = 1'b1;

    localparam logic [5:0] MAX_COUNT_RST = 6'd32;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] amp;
    } t_peak;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] peak_position;
        logic signed [31:0] peak_amplitude;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_position;
        logic signed [31:0] out_amplitude;
        logic               is_last;
        logic               is_empty;
    } t_out_item;

endpackage

FILE: rtl/core/top_n_peak_heap.sv
// ----------------------------------------------------------------------------
// top_n_peak_heap
// Keeps the largest-amplitude peaks in a binary min-heap held in a
// single-port-write, registered-read memory; drains them in ascending order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in  (opcode, position,
//          |           |                         |        amplitude)
//  out     | output    | o_out_valid/i_out_stall | o_out (position, amplitude,
//          |           |                         |        is_last, is_empty)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One request at a time; o_in_stall is high from acceptance until it is done.
//  Insert: written directly into an empty heap, else each parent is read and
//  then compared/moved, plus a put step when the peak climbs to the root.
//  Root replace: read the root, compare, then per level descended read left,
//  read right and compare/move, then place it; a drain pop reads the root,
//  outputs it and runs the same descent. The single read port sets this order.
//  i_rst_n clears control state only; the heap memory is never cleared.
//  A stalled result holds.
// ----------------------------------------------------------------------------
module top_n_peak_heap #(
    parameter int CAPACITY = tnph_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tnph_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tnph_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tnph_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tnph_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tnph_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = IW + 2;
    localparam int LW = (CW > 6) ? CW : 6;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_UP_RD    = 12'b0000_0000_0010,
        S_UP_CMP   = 12'b0000_0000_0100,
        S_PUT      = 12'b0000_0000_1000,
        S_ROOT_RD  = 12'b0000_0001_0000,
        S_ROOT_CMP = 12'b0000_0010_0000,
        S_DN_L     = 12'b0000_0100_0000,
        S_DN_R     = 12'b0000_1000_0000,
        S_DN_CMP   = 12'b0001_0000_0000,
        S_POP_RD   = 12'b0010_0000_0000,
        S_POP_OUT  = 12'b0100_0000_0000,
        S_EMPTY    = 12'b1000_0000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_held, n_held;
    logic [CW-1:0]   r_bound, n_bound;
    logic [IW-1:0]   r_hole, n_hole;
    t_peak           r_x, n_x;
    t_peak           r_child, n_child;
    logic            r_drain, n_drain;
    logic            r_out_valid;
    t_out_item       r_out, n_out;
    logic            out_load;
    logic [5:0]      r_max_count;
    logic            r_keep_first;

    t_peak           mem [CAPACITY];
    t_peak           r_rd_data;
    logic            rd_en, wr_en;
    logic [IW-1:0]   rd_addr, wr_addr;
    t_peak           wr_data;

    logic [LW-1:0]   limit, mc_ext, cap_ext;
    logic            full, out_free;
    logic [IW-1:0]   parent;
    logic [KW-1:0]   left, right, bound_ext;
    logic            has_left, has_right, take_right;
    t_peak           pick;
    logic [IW-1:0]   pick_idx;
    logic [CW-1:0]   held_dec;

    logic            r_load_x;
    t_peak           x_cur;

    // limit = max_count clamped to 1..CAPACITY
    always_comb begin
        mc_ext  = LW'(r_max_count);
        cap_ext = LW'(CAPACITY);
        if (mc_ext == '0) begin
            limit = LW'(1);
        end else if (mc_ext > cap_ext) begin
            limit = cap_ext;
        end else begin
            limit = mc_ext;
        end
        full = LW'(r_held) >= limit;
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign parent    = (r_hole - IW'(1)) >> 1;
    assign left      = {1'b0, r_hole, 1'b1};
    assign right     = left + KW'(1);
    assign bound_ext = KW'(r_bound);
    assign has_left  = left < bound_ext;
    assign has_right = right < bound_ext;
    assign held_dec  = r_held - CW'(1);

    // left wins ties
    assign take_right = has_right && ($signed(r_rd_data.amp) < $signed(r_child.amp));
    assign pick       = take_right ? r_rd_data : r_child;
    assign pick_idx   = take_right ? right[IW-1:0] : left[IW-1:0];

    // S_POP_OUT reads the last leaf; it arrives in r_rd_data on the S_DN_L
    // entry and is taken from there, then held in r_x for the descent.
    assign x_cur = r_load_x ? r_rd_data : r_x;

    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_bound  = r_bound;
        n_hole   = r_hole;
        n_x      = r_x;
        n_child  = r_child;
        n_drain  = r_drain;
        n_out    = r_out;
        out_load = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_hole;
        wr_data  = r_x;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.opcode == OP_OFFER) begin
                        n_drain = 1'b0;
                        n_x.pos = i_in.peak_position;
                        n_x.amp = i_in.peak_amplitude;
                        if (!full) begin
                            n_hole  = r_held[IW-1:0];
                            n_held  = r_held + CW'(1);
                            n_state = (r_held == '0) ? S_PUT : S_UP_RD;
                        end else if (!r_keep_first) begin
                            n_state = S_ROOT_RD;
                        end
                    end else begin
                        n_drain = 1'b1;
                        n_state = (r_held == '0) ? S_EMPTY : S_POP_RD;
                    end
                end
            end
            S_UP_RD: begin
                rd_en   = 1'b1;
                rd_addr = parent;
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if ($signed(r_rd_data.amp) > $signed(r_x.amp)) begin
                    wr_data = r_rd_data;
                    n_hole  = parent;
                    n_state = (parent == '0) ? S_PUT : S_UP_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                n_state = S_IDLE;
            end
            S_ROOT_RD: begin
                rd_en   = 1'b1;
                n_state = S_ROOT_CMP;
            end
            S_ROOT_CMP: begin
                if ($signed(r_x.amp) > $signed(r_rd_data.amp)) begin
                    n_hole  = '0;
                    n_bound = r_held;
                    n_state = S_DN_L;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DN_L: begin
                n_x = x_cur;
                if (has_left) begin
                    rd_en   = 1'b1;
                    rd_addr = left[IW-1:0];
                    n_state = S_DN_R;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = x_cur;
                    n_state = r_drain ? S_POP_RD : S_IDLE;
                end
            end
            S_DN_R: begin
                n_child = r_rd_data;
                if (has_right) begin
                    rd_en   = 1'b1;
                    rd_addr = right[IW-1:0];
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                wr_en = 1'b1;
                if ($signed(r_x.amp) > $signed(pick.amp)) begin
                    wr_data = pick;
                    n_hole  = pick_idx;
                    n_state = S_DN_L;
                end else begin
                    n_state = r_drain ? S_POP_RD : S_IDLE;
                end
            end
            S_POP_RD: begin
                rd_en   = 1'b1;
                n_state = S_POP_OUT;
            end
            S_POP_OUT: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    n_out.out_position  = r_rd_data.pos;
                    n_out.out_amplitude = r_rd_data.amp;
                    n_out.is_last       = (held_dec == '0);
                    n_out.is_empty      = 1'b0;
                    n_held              = held_dec;
                    if (held_dec == '0) begin
                        n_drain = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        // last leaf moves to the root and sifts down
                        rd_en   = 1'b1;
                        rd_addr = held_dec[IW-1:0];
                        n_hole  = '0;
                        n_bound = held_dec;
                        n_state = S_DN_L;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    n_out.out_position  = '0;
                    n_out.out_amplitude = '0;
                    n_out.is_last       = 1'b1;
                    n_out.is_empty      = 1'b1;
                    n_drain             = 1'b0;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held       <= '0;
            r_drain      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max_count  <= MAX_COUNT_RST;
            r_keep_first <= 1'b0;
            r_load_x     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_drain  <= n_drain;
            r_load_x <= (r_state == S_POP_OUT) && rd_en;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MAX_COUNT:  r_max_count  <= i_cfg_data;
                    REG_KEEP_FIRST: r_keep_first <= i_cfg_data[0];
                    default:        r_max_count  <= r_max_count;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bound <= n_bound;
        r_hole  <= n_hole;
        r_child <= n_child;
        r_x     <= n_x;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
